>>> rtl/lkvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int DATA_W          = 32;
   localparam int CAP_W           = 5;

   localparam logic [CAP_W-1:0]         CAP_RESET  = 5'd16;
   localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;
   localparam logic signed [DATA_W-1:0] PUT_VALUE  = 32'sd0;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   typedef struct packed {
      logic                     func;
      logic signed [DATA_W-1:0] lookup_key;
      logic signed [DATA_W-1:0] store_value;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] read_value;
      logic                     evicted;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE
   } state_type;

endpackage

>>> rtl/lru_key_value_cache_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
//  channel | ports                         | direction | content
//  --------+-------------------------------+-----------+-------------------------
//  req     | req_valid req_ready req_data  | in        | func, key, value
//  rsp     | rsp_valid rsp_ready rsp_data  | out       | hit, read value, evicted
//  csr     | csr_valid csr_ready csr_data  | in        | capacity in use
//
//  Each item passes through the match state (key compare over all lanes plus
//  value memory read), then the update state (age update and value write-back).
//  Ready rises again in the write-back cycle, so a new item is taken while the last one is written back.
//  Reset clears the fill count and the output stage; no clearing pass.
//  A stalled result holds the write-back cycle until the response is taken.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit
   import lkvc_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // state and storage
   state_type                 state_ff, state_in;
   logic [CAP_W-1:0]          cap_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [DATA_W-1:0]         key_ff [ENTRIES];
   logic [IDX_W-1:0]          age_ff [ENTRIES];
   logic [DATA_W-1:0]         val_mem [ENTRIES];
   logic [DATA_W-1:0]         val_rd_ff;
   req_type                   req_ff;

   // decision registered at the end of the match cycle
   logic [IDX_W-1:0]          slot_ff, slot_in;
   logic [CNT_W-1:0]          old_age_ff, old_age_in;
   logic                      touch_ff, touch_in;
   logic                      new_key_ff, new_key_in;
   logic                      grow_ff, grow_in;
   logic                      hit_ff, hit_in;
   logic                      evict_ff, evict_in;

   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;

   logic [ENTRIES-1:0]        lane_valid, match_vec, victim_vec;
   logic [IDX_W-1:0]          hit_idx, victim_idx;
   logic [CNT_W-1:0]          hit_age;
   logic                      room;
   logic [CAP_W-1:0]          cap_floor;
   logic                      req_take, finish;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // entries fill from slot 0 upwards and never leave, so the fill count
   // doubles as the valid map
   always_comb begin
      for (int j = 0; j < ENTRIES; j++) begin
         lane_valid[j] = CNT_W'(j) < count_ff;
         match_vec[j]  = lane_valid[j] && (key_ff[j] == req_ff.lookup_key);
         victim_vec[j] = lane_valid[j] && (CNT_W'(age_ff[j]) == count_ff - 1'b1);
      end
   end

   // match and victim vectors are at most one-hot: OR encode
   always_comb begin
      hit_idx    = '0;
      victim_idx = '0;
      hit_age    = '0;
      for (int j = 0; j < ENTRIES; j++) begin
         hit_idx    = hit_idx    | (match_vec[j]  ? IDX_W'(j) : '0);
         victim_idx = victim_idx | (victim_vec[j] ? IDX_W'(j) : '0);
         hit_age    = hit_age    | (match_vec[j]  ? CNT_W'(age_ff[j]) : '0);
      end
   end

   assign cap_floor = (cap_ff == '0) ? CAP_W'(1) : cap_ff;
   assign room      = (CMP_W'(count_ff) < CMP_W'(cap_floor))
                   && (count_ff < CNT_W'(ENTRIES));

   always_comb begin
      hit_in     = |match_vec;
      slot_in    = hit_idx;
      old_age_in = hit_age;
      touch_in   = hit_in;
      new_key_in = 1'b0;
      grow_in    = 1'b0;
      evict_in   = 1'b0;
      if (!hit_in && req_ff.func == FUNC_PUT) begin
         touch_in   = 1'b1;
         new_key_in = 1'b1;
         if (room) begin
            slot_in    = IDX_W'(count_ff);
            old_age_in = count_ff;
            grow_in    = 1'b1;
         end else begin
            slot_in    = victim_idx;
            old_age_in = count_ff - 1'b1;
            evict_in   = 1'b1;
         end
      end
   end

   // next state and handshake
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      finish    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) state_in = ST_MATCH;
         end
         ST_MATCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            finish    = !rsp_valid_ff || rsp_ready;
            req_ready = finish;
            if (finish) state_in = req_valid ? ST_MATCH : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_take = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) cap_ff <= csr_data;
         if (finish && grow_ff) count_ff <= count_ff + 1'b1;
         if (finish) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) req_ff <= req_data;
      if (state_ff == ST_MATCH) begin
         slot_ff    <= slot_in;
         old_age_ff <= old_age_in;
         touch_ff   <= touch_in;
         new_key_ff <= new_key_in;
         grow_ff    <= grow_in;
         hit_ff     <= hit_in;
         evict_ff   <= evict_in;
         val_rd_ff  <= val_mem[hit_idx];
      end
      if (finish) begin
         rsp_ff.hit     <= hit_ff;
         rsp_ff.evicted <= evict_ff;
         if (req_ff.func == FUNC_PUT) rsp_ff.read_value <= PUT_VALUE;
         else if (hit_ff)             rsp_ff.read_value <= val_rd_ff;
         else                         rsp_ff.read_value <= MISS_VALUE;
         if (req_ff.func == FUNC_PUT) val_mem[slot_ff] <= req_ff.store_value;
      end
   end

   // key and age lanes
   always_ff @(posedge clock) begin
      for (int j = 0; j < ENTRIES; j++) begin
         if (finish && touch_ff) begin
            if (slot_ff == IDX_W'(j)) begin
               age_ff[j] <= '0;
               if (new_key_ff) key_ff[j] <= req_ff.lookup_key;
            end else if (lane_valid[j] && CNT_W'(age_ff[j]) < old_age_ff) begin
               age_ff[j] <= age_ff[j] + 1'b1;
            end
         end
      end
   end

   // checks
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("response raised outside write-back");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("fill count beyond entries");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff))
                     || (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("fill count jumped");

   a_no_take_in_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MATCH) |-> !req_ready)
      else $error("request taken during compare");

   a_hit_not_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.hit && rsp_ff.evicted))
      else $error("hit and eviction together");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU key-value cache. Gets and puts are fed
// through the request channel and each one's response is predicted by a
// behavioural copy of the cache that tracks keys, values and recency ranks.
// The capacity register is swept through its extremes between phases, and
// both channels see random gaps, a long response stall and a full drain.
// ----------------------------------------------------------------------------
module tb_top;
   import lkvc_pkg::*;

   localparam int SLOTS       = ENTRIES_DEFAULT;
   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_TAIL  = 6;
   localparam int PHASE_ITEMS = 95;
   localparam int POOL_SIZE   = 24;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data  = '0;

   // behavioural copy of the cache
   logic signed [DATA_W-1:0] model_key  [SLOTS];
   logic signed [DATA_W-1:0] model_val  [SLOTS];
   logic                     model_live [SLOTS];
   logic [3:0]               model_rank [SLOTS];
   int                       model_fill;
   logic [CAP_W-1:0]         model_cap;

   rsp_type pending_rsp[$];

   logic signed [DATA_W-1:0] key_pool [POOL_SIZE];

   int  mismatches   = 0;
   int  sent_count   = 0;
   int  rsp_count    = 0;
   int  hit_count    = 0;
   int  evict_count  = 0;
   int  cap_writes   = 0;
   bit  calm         = 1'b0;
   bit  hold_req     = 1'b0;

   lru_key_value_cache_unit #(
      .ENTRIES (SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("tb_top: timeout, %0d responses still outstanding", pending_rsp.size());
      $display("tb_top NOT OK");
      $finish;
   end

   function automatic bit idle_now();
      return !calm && ($urandom_range(99) < 11);
   endfunction

   // Promote a slot to most recent; live entries more recent than it age by one.
   function automatic void promote(int slot);
      logic [3:0] old;
      old = model_rank[slot];
      for (int j = 0; j < SLOTS; j++)
         if (model_live[j] && j != slot && model_rank[j] < old)
            model_rank[j]++;
      model_rank[slot] = 4'd0;
   endfunction

   function automatic rsp_type predict_access(req_type it);
      rsp_type r;
      int      slot;
      bit      found;
      bit      any;
      int      limit;
      slot  = 0;
      found = 1'b0;
      any   = 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
         if (model_live[j] && model_key[j] == it.lookup_key) begin
            slot  = j;
            found = 1'b1;
            break;
         end
      end
      r.hit        = found;
      r.read_value = PUT_VALUE;
      r.evicted    = 1'b0;
      limit = (model_cap == 0) ? 1 : ((model_cap > SLOTS) ? SLOTS : int'(model_cap));
      if (it.func == FUNC_GET) begin
         if (found) begin
            r.read_value = model_val[slot];
            promote(slot);
         end else begin
            r.read_value = MISS_VALUE;
         end
      end else if (found) begin
         model_val[slot] = it.store_value;
         promote(slot);
      end else if (model_fill < limit) begin
         for (int j = 0; j < SLOTS; j++) begin
            if (!model_live[j]) begin
               slot = j;
               break;
            end
         end
         for (int j = 0; j < SLOTS; j++)
            if (model_live[j]) model_rank[j]++;
         model_live[slot] = 1'b1;
         model_rank[slot] = 4'd0;
         model_key[slot]  = it.lookup_key;
         model_val[slot]  = it.store_value;
         model_fill++;
      end else begin
         // victim is the first live slot holding the oldest rank
         for (int j = 0; j < SLOTS; j++) begin
            if (model_live[j] && (!any || model_rank[j] > model_rank[slot])) begin
               slot = j;
               any  = 1'b1;
            end
         end
         model_key[slot] = it.lookup_key;
         model_val[slot] = it.store_value;
         promote(slot);
         r.evicted = 1'b1;
      end
      return r;
   endfunction

   // ---- response side -------------------------------------------------------

   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end
         rsp_ready <= !idle_now();
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         hit_count   += rsp_data.hit;
         evict_count += rsp_data.evicted;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb_top: unexpected response hit=%0b val=%h ev=%0b",
                        rsp_data.hit, rsp_data.read_value, rsp_data.evicted);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.hit !== want.hit || rsp_data.read_value !== want.read_value ||
                rsp_data.evicted !== want.evicted) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("tb_top: response %0d exp hit=%0b val=%h ev=%0b got hit=%0b val=%h ev=%0b",
                           rsp_count, want.hit, want.read_value, want.evicted,
                           rsp_data.hit, rsp_data.read_value, rsp_data.evicted);
            end
         end
      end
   end

   // ---- request side --------------------------------------------------------

   task automatic send_access(input logic f, input logic [DATA_W-1:0] k,
                              input logic [DATA_W-1:0] v);
      req_type it;
      rsp_type exp_rsp;
      it.func        = f;
      it.lookup_key  = k;
      it.store_value = v;
      while (idle_now()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      exp_rsp     = predict_access(it);
      pending_rsp = {pending_rsp, exp_rsp};
      sent_count++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model_cap = cap;
      cap_writes++;
      csr_valid <= 1'b0;
   endtask

   // ---- tests ---------------------------------------------------------------

   task automatic test_basic_access();
      send_access(FUNC_GET, 32'h0000_0000, 32'h1111_1111);   // empty cache
      send_access(FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_access(FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_access(FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_access(FUNC_PUT, 32'h0000_0000, 32'h0000_0000);
      send_access(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
      send_access(FUNC_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      // stored value equal to the miss code, still a hit
      send_access(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_access(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
      send_access(FUNC_PUT, 32'h8000_0000, 32'h0000_1234);   // update in place
      send_access(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
      send_access(FUNC_GET, 32'h0000_0005, 32'h0000_0000);
      drain_results();
   endtask

   task automatic test_capacity_limits();
      // capacity below the fill count: misses reuse the oldest slot
      write_capacity(5'd1);
      send_access(FUNC_PUT, 32'd10, 32'hA5A5_A5A5);
      send_access(FUNC_GET, 32'd10, 32'h0);
      send_access(FUNC_GET, 32'h7FFF_FFFF, 32'h0);
      write_capacity(5'd0);                                  // treated as one
      send_access(FUNC_PUT, 32'd11, 32'h5A5A_5A5A);
      send_access(FUNC_GET, 32'd10, 32'h0);
      write_capacity(5'd31);                                 // clamps to the slot count
      send_access(FUNC_PUT, 32'd12, 32'h0000_0012);
      send_access(FUNC_GET, 32'd11, 32'h0);
      write_capacity(5'd17);
      send_access(FUNC_PUT, 32'd14, 32'h0000_0014);
      send_access(FUNC_GET, 32'hFFFF_FFFF, 32'h0);
      drain_results();
   endtask

   task automatic test_random_phases();
      logic [CAP_W-1:0] caps [12];
      int               span;
      int               eff;
      logic             f;
      logic [DATA_W-1:0] k;
      caps = '{5'd1, 5'd2, 5'd0, 5'd4, 5'd16, 5'd31, 5'd8, 5'd3, 5'd17, 5'd12,
               5'd16, 5'd6};
      for (int p = 0; p < 12; p++) begin
         write_capacity(caps[p]);
         calm = (p == 6);
         eff  = (caps[p] == 0) ? 1 : ((caps[p] > SLOTS) ? SLOTS : int'(caps[p]));
         span = (eff + 4 > POOL_SIZE) ? POOL_SIZE : eff + 4;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            f = 1'($urandom_range(1));
            // mostly a small working set so that hits and evictions both occur
            if ($urandom_range(99) < 85)
               k = key_pool[$urandom_range(span - 1)];
            else
               k = $urandom;
            send_access(f, k, $urandom);
         end
         calm = 1'b0;
      end
      drain_results();
   endtask

   task automatic test_backpressure();
      // response side stalls for a long stretch; requests pile up behind it
      write_capacity(5'd16);
      hold_req = 1'b1;
      for (int n = 0; n < 30; n++)
         send_access(1'($urandom_range(1)), key_pool[$urandom_range(POOL_SIZE - 1)],
                     $urandom);
      drain_results();
   endtask

   initial begin
      int waited;
      for (int j = 0; j < SLOTS; j++) begin
         model_key[j]  = '0;
         model_val[j]  = '0;
         model_live[j] = 1'b0;
         model_rank[j] = 4'd0;
      end
      model_fill = 0;
      model_cap  = CAP_RESET;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'hFFFF_FFFF;
      key_pool[3] = 32'h0000_0000;
      for (int j = 4; j < POOL_SIZE; j++) key_pool[j] = $urandom;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_access();
      test_capacity_limits();
      test_random_phases();
      test_backpressure();

      req_valid <= 1'b0;
      waited = 0;
      while (pending_rsp.size() != 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_TAIL) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $display("tb_top: %0d responses never arrived", pending_rsp.size());
         mismatches++;
      end

      $display("tb_top: %0d accesses, %0d responses (%0d hits, %0d evictions), %0d errors",
               sent_count, rsp_count, hit_count, evict_count, mismatches);
      $display("tb_top: %0d capacity writes from 0 to 31, random gaps and one long stall",
               cap_writes);
      if (mismatches == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
